### rtl/u16u8_pkg.sv
package u16u8_pkg;

  // Byte emitted for an unpaired or misplaced surrogate
  localparam logic [7:0] QMARK = 8'h3F;

  // Upper six bits of the two surrogate ranges
  localparam logic [5:0] SUR_HIGH_TAG = 6'b110110;
  localparam logic [5:0] SUR_LOW_TAG  = 6'b110111;

  // Offset added to a surrogate pair's twenty payload bits
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // Limits of the one- and two-byte forms
  localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

  // Lead-byte marks
  localparam logic [4:0] LEAD4_MARK = 5'b11110;
  localparam logic [3:0] LEAD3_MARK = 4'b1110;
  localparam logic [2:0] LEAD2_MARK = 3'b110;
  localparam logic [1:0] CONT_MARK  = 2'b10;

  // Job queue between front and back (depth is a power of two)
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Maximum results per unit
  localparam int MAX_BYTES = 4;

  // One classified unit: bytes in emission order, count of results (1..4),
  // whether the last result ends the string, and whether it is a bare marker
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      ended;
    logic                      bare;
  } job_t;

endpackage

### rtl/u16u8_ifs.sv
interface u16u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

interface u16u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last_of_run;
  logic       string_end;

  modport source (output valid, output out_byte, output byte_valid,
                  output last_of_run, output string_end, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input last_of_run, input string_end, output ready);
endinterface

### rtl/u16u8_front.sv
module u16u8_front (
  input  logic           clk,
  input  logic           rst,
  u16u8_in_if.sink       unit_in,
  output u16u8_pkg::job_t job,
  output logic           push,
  input  logic           full
);
  import u16u8_pkg::*;

  logic [9:0]  held_high_bits;
  logic        high_pending;
  logic        string_stopped;

  logic [15:0] u;
  logic        last;
  logic        accept;
  logic        is_high;
  logic        is_low;
  logic        paired;
  logic [20:0] cp;
  logic [2:0][7:0] ub;
  logic [1:0]  un;
  logic        unit_end;
  logic        hold_high;
  logic [2:0]  nb;
  logic        ended;

  assign unit_in.ready = !full;
  assign accept = unit_in.valid && unit_in.ready;

  assign u       = unit_in.code_unit;
  assign last    = unit_in.last_unit;
  assign is_high = (u[15:10] == SUR_HIGH_TAG);
  assign is_low  = (u[15:10] == SUR_LOW_TAG);
  assign paired  = high_pending && is_low;
  assign cp      = {1'b0, held_high_bits, u[9:0]} + SUPP_BASE;

  // Encode the unit on its own
  always_comb begin
    ub        = '0;
    un        = 2'd0;
    unit_end  = 1'b0;
    hold_high = 1'b0;
    if (u == 16'h0000) begin
      unit_end = 1'b1;
    end else if (u < ONE_BYTE_LIMIT) begin
      ub[0] = u[7:0];
      un    = 2'd1;
    end else if (u < TWO_BYTE_LIMIT) begin
      ub[0] = {LEAD2_MARK, u[10:6]};
      ub[1] = {CONT_MARK, u[5:0]};
      un    = 2'd2;
    end else if (is_high) begin
      if (last) begin
        ub[0] = QMARK;
        un    = 2'd1;
      end else begin
        hold_high = 1'b1;
      end
    end else if (is_low) begin
      ub[0] = QMARK;
      un    = 2'd1;
    end else begin
      ub[0] = {LEAD3_MARK, u[15:12]};
      ub[1] = {CONT_MARK, u[11:6]};
      ub[2] = {CONT_MARK, u[5:0]};
      un    = 2'd3;
    end
  end

  // Assemble the job: pair, or optional '?' followed by the unit's bytes
  always_comb begin
    job.bytes = '0;
    nb        = 3'd0;
    if (paired) begin
      job.bytes[0] = {LEAD4_MARK, cp[20:18]};
      job.bytes[1] = {CONT_MARK, cp[17:12]};
      job.bytes[2] = {CONT_MARK, cp[11:6]};
      job.bytes[3] = {CONT_MARK, cp[5:0]};
      nb           = 3'd4;
    end else if (high_pending) begin
      job.bytes[0] = QMARK;
      job.bytes[1] = ub[0];
      job.bytes[2] = ub[1];
      job.bytes[3] = ub[2];
      nb           = {1'b0, un} + 3'd1;
    end else begin
      job.bytes[0] = ub[0];
      job.bytes[1] = ub[1];
      job.bytes[2] = ub[2];
      nb           = {1'b0, un};
    end
    ended     = last || (!paired && unit_end);
    job.ended = ended;
    job.bare  = 1'b0;
    job.count = nb;
    if (ended && (nb == 3'd0)) begin
      job.bare  = 1'b1;
      job.count = 3'd1;
    end
  end

  // Queue only units that cause at least one result
  assign push = accept && !string_stopped && (job.count != 3'd0);

  // Advance string state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      held_high_bits <= '0;
      high_pending   <= 1'b0;
      string_stopped <= 1'b0;
    end else if (accept) begin
      if (last) begin
        held_high_bits <= '0;
        high_pending   <= 1'b0;
        string_stopped <= 1'b0;
      end else if (!string_stopped) begin
        high_pending <= !paired && hold_high;
        if (!paired && hold_high) begin
          held_high_bits <= u[9:0];
        end else begin
          held_high_bits <= '0;
        end
        if (!paired && unit_end) begin
          string_stopped <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/u16u8_queue.sv
module u16u8_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u16u8_pkg::job_t push_job,
  input  logic            pop,
  output u16u8_pkg::job_t head_job,
  output logic            full,
  output logic            empty
);
  import u16u8_pkg::*;

  job_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full     = (count == Q_CNT_W'(Q_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slots[rd_ptr];

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/u16u8_back.sv
module u16u8_back (
  input  logic            clk,
  input  logic            rst,
  input  u16u8_pkg::job_t head_job,
  input  logic            empty,
  output logic            pop,
  u16u8_out_if.source     byte_out
);
  import u16u8_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       final_byte;

  assign load       = !empty && (!byte_out.valid || byte_out.ready);
  assign final_byte = ({1'b0, idx} == (head_job.count - 3'd1));
  assign pop        = load && final_byte;

  // Step through the head job one byte per cycle while the output register can load
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= final_byte ? 2'd0 : idx + 2'd1;
    end
  end

  // Hold the result in the output register until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_out.valid <= 1'b0;
    end else if (load) begin
      byte_out.valid <= 1'b1;
    end else if (byte_out.ready) begin
      byte_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_out.out_byte    <= head_job.bytes[idx];
      byte_out.byte_valid  <= !head_job.bare;
      byte_out.last_of_run <= final_byte;
      byte_out.string_end  <= final_byte && head_job.ended;
    end
  end

endmodule

### rtl/utf16le_to_utf8_stream.sv
// UTF-16LE to UTF-8 stream converter. Each accepted word on unit_in is one
// 16-bit code unit; byte_out delivers one UTF-8 byte per word, with
// last_of_run on the final byte a unit caused and string_end where a zero
// unit or the buffer end finished the string (a bare marker with
// byte_valid low is sent when nothing else carries that end). The bytes a
// unit causes, one to four, leave in turn, since the back end serializes
// through a single one-byte output register; units that cause nothing
// (held high surrogate, units after the string stopped) queue no job.
// A two-entry job queue sits between the classifier and the serializer,
// so input is accepted while earlier units still drain. With the queue and
// output register empty, the first byte of a unit passes through a queue
// slot and then the output register before it is presented on byte_out.
module utf16le_to_utf8_stream (
  input  logic         clk,
  input  logic         rst,
  u16u8_in_if.sink     unit_in,
  u16u8_out_if.source  byte_out
);
  import u16u8_pkg::*;

  job_t front_job;
  job_t head_job;
  logic push;
  logic pop;
  logic full;
  logic empty;

  u16u8_front u_front (
    .clk     (clk),
    .rst     (rst),
    .unit_in (unit_in),
    .job     (front_job),
    .push    (push),
    .full    (full)
  );

  u16u8_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (front_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (full),
    .empty    (empty)
  );

  u16u8_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_job (head_job),
    .empty    (empty),
    .pop      (pop),
    .byte_out (byte_out)
  );

endmodule

### rtl/u16u8_checker.sv
module u16u8_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       last_of_run,
  input logic       string_end
);

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(byte_valid) && $stable(last_of_run) && $stable(string_end))
    else $error("stalled result changed");

  // End of string falls only on the final byte of a unit
  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> last_of_run)
    else $error("string_end without last_of_run");

  // A bare marker is a zero byte that ends the unit and the string
  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_byte == 8'h00 && last_of_run && string_end)
    else $error("malformed end marker");

  // Drop any result during reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind utf16le_to_utf8_stream u16u8_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (byte_out.valid),
  .out_ready   (byte_out.ready),
  .out_byte    (byte_out.out_byte),
  .byte_valid  (byte_out.byte_valid),
  .last_of_run (byte_out.last_of_run),
  .string_end  (byte_out.string_end)
);

### tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD      = 300;
  localparam int PHASE_UNITS    = 80;
  localparam int DRAIN_CYCLES   = 10;

  localparam logic [7:0]  REPLACEMENT = 8'h3F;
  localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;
  localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;

  // One code unit waiting to go into the block
  typedef struct packed {
    logic [15:0] code;
    logic        fin;
  } unit_item_t;

  // One expected word on the byte channel
  typedef struct packed {
    logic [7:0] octet;
    logic       carries;
    logic       run_end;
    logic       str_end;
  } utf8_word_t;

  logic clk;
  logic rst;

  u16u8_in_if  unit_if ();
  u16u8_out_if byte_if ();

  utf16le_to_utf8_stream dut (
    .clk      (clk),
    .rst      (rst),
    .unit_in  (unit_if),
    .byte_out (byte_if)
  );

  unit_item_t pending_units[$];
  utf8_word_t expected_bytes[$];

  // Transcoder state mirrored at unit acceptance
  logic [9:0] held_bits;
  logic       high_held;
  logic       str_stopped;

  int  units_queued;
  int  units_taken;
  int  fails;
  int  quiet_cycles;
  int  send_idle_pct;
  int  recv_stall_pct;
  logic in_taken;
  logic hold_req;
  logic hold_seen;
  int  hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic utf8_word_t octet_word(input logic [7:0] b);
    return '{octet: b, carries: 1'b1, run_end: 1'b0, str_end: 1'b0};
  endfunction

  // Compute the bytes one accepted unit causes and advance the mirrored state
  function automatic void predict_unit(input logic [15:0] u, input logic last);
    utf8_word_t  run[$];
    logic        ended;
    logic        paired;
    logic [20:0] cp;
    ended  = 1'b0;
    paired = 1'b0;
    if (!str_stopped) begin
      // resolve a held high surrogate first
      if (high_held) begin
        high_held = 1'b0;
        if (u[15:10] == LOW_SURR_TAG) begin
          cp = SUPPLEMENTARY_BASE + {held_bits, u[9:0]};
          run.push_back(octet_word({5'b11110, cp[20:18]}));
          run.push_back(octet_word({2'b10, cp[17:12]}));
          run.push_back(octet_word({2'b10, cp[11:6]}));
          run.push_back(octet_word({2'b10, cp[5:0]}));
          paired = 1'b1;
        end else begin
          run.push_back(octet_word(REPLACEMENT));
        end
        held_bits = '0;
      end
      // classify the unit on its own
      if (!paired) begin
        if (u == 16'h0000) begin
          str_stopped = 1'b1;
          ended       = 1'b1;
        end else if (u < 16'h0080) begin
          run.push_back(octet_word(u[7:0]));
        end else if (u < 16'h0800) begin
          run.push_back(octet_word({3'b110, u[10:6]}));
          run.push_back(octet_word({2'b10, u[5:0]}));
        end else if (u[15:10] == HIGH_SURR_TAG) begin
          if (last) begin
            run.push_back(octet_word(REPLACEMENT));
          end else begin
            held_bits = u[9:0];
            high_held = 1'b1;
          end
        end else if (u[15:10] == LOW_SURR_TAG) begin
          run.push_back(octet_word(REPLACEMENT));
        end else begin
          run.push_back(octet_word({4'b1110, u[15:12]}));
          run.push_back(octet_word({2'b10, u[11:6]}));
          run.push_back(octet_word({2'b10, u[5:0]}));
        end
      end
      if (last) ended = 1'b1;
      // a string end with nothing to carry it gets a bare marker
      if (ended && run.size() == 0)
        run.push_back('{octet: 8'h00, carries: 1'b0, run_end: 1'b0, str_end: 1'b0});
      if (run.size() > 0) begin
        run[run.size()-1].run_end = 1'b1;
        run[run.size()-1].str_end = ended;
      end
      foreach (run[i]) expected_bytes.push_back(run[i]);
    end
    // clear everything after the buffer end
    if (last) begin
      held_bits   = '0;
      high_held   = 1'b0;
      str_stopped = 1'b0;
    end
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  task automatic queue_unit(input logic [15:0] u, input logic last);
    pending_units.push_back('{code: u, fin: last});
    units_queued++;
  endtask

  // Build one buffer of mostly well-formed text, last unit marked
  task automatic queue_random_buffer(output int n_added);
    logic [15:0] units[$];
    int len;
    int k;
    len = $urandom_range(1, 8);
    while (units.size() < len) begin
      k = $urandom_range(99);
      if (k < 30) begin
        units.push_back(16'($urandom_range(16'h0001, 16'h007F)));
      end else if (k < 48) begin
        units.push_back(16'($urandom_range(16'h0080, 16'h07FF)));
      end else if (k < 64) begin
        if ($urandom_range(1))
          units.push_back(16'($urandom_range(16'h0800, 16'hD7FF)));
        else
          units.push_back(16'($urandom_range(16'hE000, 16'hFFFF)));
      end else if (k < 82) begin
        units.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
        units.push_back(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end else if (k < 86) begin
        units.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
        if (units.size() < len) units.push_back(16'($urandom()));
      end else if (k < 89) begin
        units.push_back(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end else if (k < 93) begin
        units.push_back(16'h0000);
      end else begin
        units.push_back(16'($urandom()));
      end
    end
    foreach (units[i]) queue_unit(units[i], i == units.size() - 1);
    n_added = units.size();
  endtask

  task automatic wait_drained();
    while (units_taken != units_queued || expected_bytes.size() != 0)
      @(negedge clk);
  endtask

  // Drive code units from the pending queue
  always @(negedge clk) begin
    unit_item_t w;
    if (rst) begin
      unit_if.valid <= 1'b0;
    end else if (!unit_if.valid || in_taken) begin
      if (pending_units.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_units.pop_front();
        unit_if.valid     <= 1'b1;
        unit_if.code_unit <= w.code;
        unit_if.last_unit <= w.fin;
      end else begin
        unit_if.valid <= 1'b0;
      end
    end
  end

  // Drive byte-channel ready; hold off for a long stretch on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      byte_if.ready <= 1'b0;
    end else begin
      byte_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check output words, predict accepted units, watch for a hang
  always @(posedge clk) begin
    utf8_word_t e;
    logic in_fire;
    logic out_fire;
    if (rst) begin
      in_taken     <= 1'b0;
      quiet_cycles = 0;
    end else begin
      in_fire  = unit_if.valid && unit_if.ready;
      out_fire = byte_if.valid && byte_if.ready;
      in_taken <= in_fire;
      if (out_fire) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected word: out_byte 0x%0h byte_valid %0b", byte_if.out_byte,
                 byte_if.byte_valid);
          fails++;
        end else begin
          e = expected_bytes.pop_front();
          check_field("out_byte", e.octet, byte_if.out_byte);
          check_field("byte_valid", 8'(e.carries), 8'(byte_if.byte_valid));
          check_field("last_of_run", 8'(e.run_end), 8'(byte_if.last_of_run));
          check_field("string_end", 8'(e.str_end), 8'(byte_if.string_end));
        end
      end
      if (in_fire) begin
        predict_unit(unit_if.code_unit, unit_if.last_unit);
        units_taken++;
      end
      if (in_fire || out_fire) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    int n;
    int added;
    held_bits         = '0;
    high_held         = 1'b0;
    str_stopped       = 1'b0;
    units_queued      = 0;
    units_taken       = 0;
    fails             = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_req          = 1'b0;
    hold_seen         = 1'b0;
    hold_left         = 0;
    unit_if.valid     = 1'b0;
    unit_if.code_unit = '0;
    unit_if.last_unit = 1'b0;
    byte_if.ready     = 1'b0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // range edges of the one-, two- and three-byte forms
    queue_unit(16'h0041, 1'b0);
    queue_unit(16'h007F, 1'b0);
    queue_unit(16'h0080, 1'b0);
    queue_unit(16'h07FF, 1'b0);
    queue_unit(16'h0800, 1'b0);
    queue_unit(16'hD7FF, 1'b0);
    queue_unit(16'hE000, 1'b0);
    queue_unit(16'hFFFF, 1'b0);
    // lowest and highest surrogate pairs
    queue_unit(16'hD800, 1'b0);
    queue_unit(16'hDC00, 1'b0);
    queue_unit(16'hDBFF, 1'b0);
    queue_unit(16'hDFFF, 1'b0);
    // unpaired high before plain text and before a three-byte unit
    queue_unit(16'hD801, 1'b0);
    queue_unit(16'h0041, 1'b0);
    queue_unit(16'hD802, 1'b0);
    queue_unit(16'hFFFF, 1'b0);
    // lone low surrogate
    queue_unit(16'hDC05, 1'b0);
    // unpaired high then a zero unit, then ignored units up to the buffer end
    queue_unit(16'hD803, 1'b0);
    queue_unit(16'h0000, 1'b0);
    queue_unit(16'h1234, 1'b0);
    queue_unit(16'hD800, 1'b0);
    queue_unit(16'h0055, 1'b1);
    // buffer end on plain text, on a high surrogate, on a zero unit
    queue_unit(16'h0042, 1'b1);
    queue_unit(16'hDABC, 1'b1);
    queue_unit(16'h0000, 1'b1);
    wait_drained();

    // random buffers under each idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      // in the first phase, fill the block while the receiver holds off
      if (phase == 0) hold_req = ~hold_req;
      added = 0;
      while (added < PHASE_UNITS) begin
        queue_random_buffer(n);
        added += n;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### utf16le_to_utf8_stream.f
rtl/u16u8_pkg.sv
rtl/u16u8_ifs.sv
rtl/u16u8_front.sv
rtl/u16u8_queue.sv
rtl/u16u8_back.sv
rtl/utf16le_to_utf8_stream.sv
rtl/u16u8_checker.sv
tb/sv/tb_top.sv
